FILE: rtl/css_min_pkg.sv
// Shared types, character codes, status codes and text tables of the CSS minifier.
// No dependencies; the parser, the emitter and the top level all import it.
package css_min_pkg;

   localparam int DEFAULT_HELD_DEPTH = 16;

   localparam int HEAD_LEN  = 8;
   localparam int TRAIL_LEN = 9;
   localparam int TAG_LEN   = 7;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_SEMI   = 8'h3b;

   localparam logic [2:0] ST_RUNNING   = 3'd0;
   localparam logic [2:0] ST_DONE      = 3'd1;
   localparam logic [2:0] ST_NO_BRACE  = 3'd2;
   localparam logic [2:0] ST_NO_COLON  = 3'd3;
   localparam logic [2:0] ST_UNTERM    = 3'd4;
   localparam logic [2:0] ST_UNCLOSED  = 3'd5;
   localparam logic [2:0] ST_BAD_TAG   = 3'd6;
   localparam logic [2:0] ST_OVERFLOW  = 3'd7;

   typedef enum logic [2:0] {
      MODE_TOP   = 3'd0,
      MODE_SEL   = 3'd1,
      MODE_BLOCK = 3'd2,
      MODE_KEY   = 3'd3,
      MODE_VAL   = 3'd4,
      MODE_TAG   = 3'd5,
      MODE_STOP  = 3'd6
   } mode_type;

   // What one accepted byte asks the emitter to send, in this order:
   // header, replayed selector whitespace, up to two literals, trailer, status.
   typedef struct packed {
      logic       hdr;
      logic [1:0] lit_n;
      logic [7:0] lit0;
      logic [7:0] lit1;
      logic       trl;
      logic       stat;
      logic [2:0] code;
   } plan_type;

   function automatic logic [7:0] head_byte(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = CH_LT;
         4'd1:    c = 8'h73;
         4'd2:    c = 8'h74;
         4'd3:    c = 8'h79;
         4'd4:    c = 8'h6c;
         4'd5:    c = 8'h65;
         4'd6:    c = 8'h3e;
         4'd7:    c = CH_NL;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] trail_byte(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = CH_LT;
         4'd1:    c = 8'h2f;
         4'd2:    c = 8'h73;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h79;
         4'd5:    c = 8'h6c;
         4'd6:    c = 8'h65;
         4'd7:    c = 8'h3e;
         4'd8:    c = CH_NL;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] tag_byte(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h2f;
         3'd1:    c = 8'h73;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h79;
         3'd4:    c = 8'h6c;
         3'd5:    c = 8'h65;
         3'd6:    c = 8'h3e;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/css_min_parse.sv
// Parser of the CSS minifier: mode register, counters and the per-byte decision.
// Depends on css_min_pkg; feeds plans and whitespace writes to css_min_seq.
module css_min_parse
   import css_min_pkg::*;
#(
   parameter int HELD_DEPTH = DEFAULT_HELD_DEPTH,
   parameter int CNT_W      = $clog2(HELD_DEPTH + 1),
   parameter int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output plan_type         plan,
   output logic [CNT_W-1:0] plan_rep,
   output logic             hold_we,
   output logic [IDX_W-1:0] hold_idx,
   output logic [7:0]       hold_data
);

   logic             close_tag_ff;
   mode_type         mode_ff, mode_in;
   logic             started_ff, started_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             need_ff, need_in;
   logic             word_ff, word_in;
   logic             semi_ff, semi_in;
   logic [2:0]       tag_ff, tag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         close_tag_ff <= 1'b0;
      end else if (csr_we) begin
         close_tag_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_TOP;
         started_ff <= 1'b0;
         count_ff   <= '0;
         need_ff    <= 1'b0;
         word_ff    <= 1'b0;
         semi_ff    <= 1'b0;
         tag_ff     <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         need_ff    <= need_in;
         word_ff    <= word_in;
         semi_ff    <= semi_in;
         tag_ff     <= tag_in;
      end
   end

   always_comb begin
      logic space;
      space      = (in_byte <= CH_SPACE);
      mode_in    = mode_ff;
      started_in = 1'b1;
      count_in   = count_ff;
      need_in    = need_ff;
      word_in    = word_ff;
      semi_in    = semi_ff;
      tag_in     = tag_ff;
      plan       = '0;
      plan.hdr   = !started_ff;
      plan_rep   = '0;
      hold_we    = 1'b0;
      hold_idx   = count_ff[IDX_W-1:0];
      hold_data  = in_byte;

      case (mode_ff)
         MODE_TOP: begin
            if (!space) begin
               if (in_byte == CH_LT) begin
                  if (close_tag_ff) begin
                     tag_in  = '0;
                     mode_in = MODE_TAG;
                  end else begin
                     plan.trl  = 1'b1;
                     plan.stat = 1'b1;
                     plan.code = ST_DONE;
                     mode_in   = MODE_STOP;
                  end
               end else if (in_byte == CH_LBRACE) begin
                  plan.lit_n = 2'd1;
                  plan.lit0  = CH_LBRACE;
                  semi_in    = 1'b0;
                  mode_in    = MODE_BLOCK;
               end else begin
                  plan.lit_n = 2'd1;
                  plan.lit0  = in_byte;
                  count_in   = '0;
                  mode_in    = MODE_SEL;
               end
            end
         end
         MODE_SEL: begin
            if (in_byte == CH_LBRACE) begin
               count_in   = '0;
               plan.lit_n = 2'd1;
               plan.lit0  = CH_LBRACE;
               semi_in    = 1'b0;
               mode_in    = MODE_BLOCK;
            end else if (space) begin
               if (count_ff >= CNT_W'(HELD_DEPTH)) begin
                  plan.stat = 1'b1;
                  plan.code = ST_OVERFLOW;
                  mode_in   = MODE_STOP;
               end else begin
                  hold_we  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               // The held whitespace was not trailing after all: replay it first.
               plan_rep   = count_ff;
               count_in   = '0;
               plan.lit_n = 2'd1;
               plan.lit0  = in_byte;
            end
         end
         MODE_BLOCK: begin
            if (!space) begin
               if (in_byte == CH_RBRACE) begin
                  semi_in    = 1'b0;
                  plan.lit_n = 2'd2;
                  plan.lit0  = CH_RBRACE;
                  plan.lit1  = CH_NL;
                  mode_in    = MODE_TOP;
               end else begin
                  semi_in = 1'b0;
                  if (in_byte == CH_COLON) begin
                     mode_in = MODE_VAL;
                     need_in = 1'b0;
                     word_in = 1'b0;
                  end else begin
                     mode_in = MODE_KEY;
                  end
                  if (semi_ff) begin
                     plan.lit_n = 2'd2;
                     plan.lit0  = CH_SEMI;
                     plan.lit1  = in_byte;
                  end else begin
                     plan.lit_n = 2'd1;
                     plan.lit0  = in_byte;
                  end
               end
            end
         end
         MODE_KEY: begin
            plan.lit_n = 2'd1;
            plan.lit0  = in_byte;
            if (in_byte == CH_COLON) begin
               mode_in = MODE_VAL;
               need_in = 1'b0;
               word_in = 1'b0;
            end
         end
         MODE_VAL: begin
            if (space) begin
               word_in = 1'b0;
            end else if (in_byte == CH_SEMI) begin
               semi_in = 1'b1;
               word_in = 1'b0;
               mode_in = MODE_BLOCK;
            end else if (!word_ff && need_ff) begin
               plan.lit_n = 2'd2;
               plan.lit0  = CH_SPACE;
               plan.lit1  = in_byte;
               word_in    = 1'b1;
            end else begin
               plan.lit_n = 2'd1;
               plan.lit0  = in_byte;
               need_in    = 1'b1;
               word_in    = 1'b1;
            end
         end
         MODE_TAG: begin
            if (tag_ff < 3'(TAG_LEN) && in_byte == tag_byte(tag_ff)) begin
               tag_in = tag_ff + 1'b1;
               if (tag_in >= 3'(TAG_LEN)) begin
                  plan.trl  = 1'b1;
                  plan.stat = 1'b1;
                  plan.code = ST_DONE;
                  mode_in   = MODE_STOP;
               end
            end else begin
               plan.stat = 1'b1;
               plan.code = ST_BAD_TAG;
               mode_in   = MODE_STOP;
            end
         end
         default: begin
         end
      endcase

      if (in_last) begin
         case (mode_in)
            MODE_TOP: begin
               plan.trl  = 1'b1;
               plan.stat = 1'b1;
               plan.code = ST_DONE;
            end
            MODE_SEL: begin
               plan.stat = 1'b1;
               plan.code = ST_NO_BRACE;
            end
            MODE_BLOCK: begin
               plan.stat = 1'b1;
               plan.code = ST_UNCLOSED;
            end
            MODE_KEY: begin
               plan.stat = 1'b1;
               plan.code = ST_NO_COLON;
            end
            MODE_VAL: begin
               plan.stat = 1'b1;
               plan.code = ST_UNTERM;
            end
            MODE_TAG: begin
               plan.stat = 1'b1;
               plan.code = ST_BAD_TAG;
            end
            default: begin
            end
         endcase
         mode_in    = MODE_TOP;
         started_in = 1'b0;
         count_in   = '0;
         need_in    = 1'b0;
         word_in    = 1'b0;
         semi_in    = 1'b0;
         tag_in     = '0;
      end
   end

endmodule

FILE: rtl/css_min_seq.sv
// Emitter of the CSS minifier: plan register, held-whitespace shift line and
// the result register. Depends on css_min_pkg; driven by css_min_parse.
module css_min_seq
   import css_min_pkg::*;
#(
   parameter int HELD_DEPTH = DEFAULT_HELD_DEPTH,
   parameter int CNT_W      = $clog2(HELD_DEPTH + 1),
   parameter int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  plan_type         plan,
   input  logic [CNT_W-1:0] plan_rep,
   input  logic             hold_we,
   input  logic [IDX_W-1:0] hold_idx,
   input  logic [7:0]       hold_data,
   output logic             free,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   logic [7:0]       held_ff [HELD_DEPTH];
   logic             hdr_ff, trl_ff, stat_ff;
   logic [3:0]       idx_ff;
   logic [CNT_W-1:0] rep_ff;
   logic [1:0]       litn_ff;
   logic [7:0]       lit0_ff, lit1_ff;
   logic [2:0]       code_ff;

   logic             valid_ff, bvalid_ff, last_ff;
   logic [7:0]       byte_ff;
   logic [2:0]       status_ff;

   logic             busy, emit, cur_last, cur_bvalid, rep_now;
   logic [7:0]       cur_byte;
   logic [2:0]       cur_status;

   // Pick the element at the head of the plan and whether it is the final one.
   always_comb begin
      logic rep_any, lit_any;
      rep_any    = (rep_ff != '0);
      lit_any    = (litn_ff != 2'd0);
      busy       = hdr_ff || rep_any || lit_any || trl_ff || stat_ff;
      cur_byte   = 8'h00;
      cur_bvalid = 1'b1;
      cur_status = ST_RUNNING;
      cur_last   = 1'b0;
      rep_now    = 1'b0;
      if (hdr_ff) begin
         cur_byte = head_byte(idx_ff);
         cur_last = (idx_ff == 4'(HEAD_LEN - 1)) && !(rep_any || lit_any || trl_ff || stat_ff);
      end else if (rep_any) begin
         rep_now  = 1'b1;
         cur_byte = held_ff[0];
         cur_last = (rep_ff == CNT_W'(1)) && !(lit_any || trl_ff || stat_ff);
      end else if (lit_any) begin
         cur_byte = lit0_ff;
         cur_last = (litn_ff == 2'd1) && !(trl_ff || stat_ff);
      end else if (trl_ff) begin
         cur_byte = trail_byte(idx_ff);
         cur_last = (idx_ff == 4'(TRAIL_LEN - 1)) && !stat_ff;
      end else begin
         cur_bvalid = 1'b0;
         cur_status = code_ff;
         cur_last   = 1'b1;
      end
   end

   assign emit = busy && (!valid_ff || rsp_tready);
   assign free = !busy || (emit && cur_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= 1'b0;
         trl_ff  <= 1'b0;
         stat_ff <= 1'b0;
         rep_ff  <= '0;
         litn_ff <= 2'd0;
         idx_ff  <= 4'd0;
      end else if (load) begin
         hdr_ff  <= plan.hdr;
         trl_ff  <= plan.trl;
         stat_ff <= plan.stat;
         rep_ff  <= plan_rep;
         litn_ff <= plan.lit_n;
         idx_ff  <= 4'd0;
      end else if (emit) begin
         if (hdr_ff) begin
            if (idx_ff == 4'(HEAD_LEN - 1)) begin
               hdr_ff <= 1'b0;
               idx_ff <= 4'd0;
            end else begin
               idx_ff <= idx_ff + 4'd1;
            end
         end else if (rep_now) begin
            rep_ff <= rep_ff - 1'b1;
         end else if (litn_ff != 2'd0) begin
            litn_ff <= litn_ff - 2'd1;
         end else if (trl_ff) begin
            if (idx_ff == 4'(TRAIL_LEN - 1)) begin
               trl_ff <= 1'b0;
               idx_ff <= 4'd0;
            end else begin
               idx_ff <= idx_ff + 4'd1;
            end
         end else begin
            stat_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lit0_ff <= plan.lit0;
         lit1_ff <= plan.lit1;
         code_ff <= plan.code;
      end else if (emit && !hdr_ff && !rep_now && litn_ff != 2'd0) begin
         lit0_ff <= lit1_ff;
      end
   end

   // Held whitespace: written at the fill position, drained from the head.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
         if (hold_we && hold_idx == IDX_W'(i)) begin
            held_ff[i] <= hold_data;
         end else if (emit && rep_now && i < HELD_DEPTH - 1) begin
            held_ff[i] <= held_ff[(i + 1) % HELD_DEPTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= cur_byte;
         bvalid_ff <= cur_bvalid;
         status_ff <= cur_status;
         last_ff   <= cur_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, status_ff, byte_ff};
   assign rsp_tuser  = bvalid_ff;
   assign rsp_tlast  = last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!busy || (emit && cur_last)))
      else $error("plan loaded while earlier results are still pending");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("status result is not the last of its byte");

   a_status_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[10:8] != ST_RUNNING))
      else $error("status result carries the running code");

   a_byte_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[10:8] == ST_RUNNING))
      else $error("byte result carries a status code");

   a_replay_idle_input: assert property (@(posedge clock) disable iff (reset)
      (emit && rep_now) |-> !load)
      else $error("new byte accepted during whitespace replay");

endmodule

FILE: rtl/css_stream_minifier_top.sv
// Top level of the CSS stream minifier: stream ports, configuration register port.
// Depends on css_min_pkg and instantiates css_min_parse and css_min_seq.
//
//   channel   direction  beat carries
//   req_*     in         one raw CSS byte and the end-of-message flag
//   rsp_*     out        one minified byte or one status code
//   csr_*     in         require_close_tag, write only, no read-back
//
// While rsp_tready is high, a byte that gives at most one result is taken every cycle:
// the parser decides everything for it in the cycle of acceptance and the emitter
// registers the result. A byte with more results holds req_tready low until its
// last result is sent, as the single result register sends one beat per cycle (up to
// 8 header bytes, held selector whitespace, two literals, 9 trailer bytes, a status).
// Reset is synchronous and active high; it clears the parser and the emitter
// but not the held whitespace, which is read only after it is written.
// A stalled rsp_tready holds the result register; one further byte is still
// accepted while a result waits, and its plan waits in the emitter.
module css_stream_minifier_top
   import css_min_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = DEFAULT_HELD_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: require_close_tag.
   input  logic        csr_we,
   input  logic        csr_wdata,
   // Input stream. tdata: in_byte[7:0]. tlast: in_last.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // Result stream. tdata: out_byte[7:0], status[10:8], zero[15:11].
   // tuser: byte_valid. tlast: run_last.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   logic             accept;
   logic             free;
   plan_type         plan;
   logic [CNT_W-1:0] plan_rep;
   logic             hold_we;
   logic [IDX_W-1:0] hold_idx;
   logic [7:0]       hold_data;

   // A beat is taken whenever the emitter's plan will be empty at this edge.
   assign req_tready = free;
   assign accept     = req_tvalid && free;

   css_min_parse #(
      .HELD_DEPTH (HELD_SPACE_DEPTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .plan      (plan),
      .plan_rep  (plan_rep),
      .hold_we   (hold_we),
      .hold_idx  (hold_idx),
      .hold_data (hold_data)
   );

   // Writes into the held whitespace only count for accepted beats.
   css_min_seq #(
      .HELD_DEPTH (HELD_SPACE_DEPTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .plan       (plan),
      .plan_rep   (plan_rep),
      .hold_we    (hold_we && accept),
      .hold_idx   (hold_idx),
      .hold_data  (hold_data),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/css_min_tb_pkg.sv
// Scoreboard for the CSS stream minifier: predicts the minified beats of each accepted byte.
// Depends on css_min_pkg for the mode enum, status codes and character codes.
package css_min_tb_pkg;
   import css_min_pkg::*;

   localparam int HELD_DEPTH = DEFAULT_HELD_DEPTH;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] status;
      logic       run_last;
   } css_beat_type;

   class css_minify_scoreboard;
      bit           close_tag_required;
      mode_type     mode;
      bit           started;
      logic [7:0]   held_ws [HELD_DEPTH];
      int unsigned  held_n;
      bit           space_due;
      bit           mid_word;
      bit           semi_held;
      int unsigned  tag_pos;
      css_beat_type minified_q[$];
      css_beat_type burst[$];
      int unsigned  mismatches;
      int unsigned  beats_checked;
      int unsigned  status_hits[8];

      function new();
         close_tag_required = 1'b0;
         rearm();
      endfunction

      // Held whitespace is left alone: it is only read after being written.
      function void rearm();
         mode = MODE_TOP;
         started = 1'b0;
         held_n = 0;
         space_due = 1'b0;
         mid_word = 1'b0;
         semi_held = 1'b0;
         tag_pos = 0;
      endfunction

      function void emit(logic [7:0] c);
         burst.push_back(css_beat_type'{out_byte: c, byte_valid: 1'b1, status: ST_RUNNING,
                                        run_last: 1'b0});
      endfunction

      function void conclude(logic [2:0] code);
         burst.push_back(css_beat_type'{out_byte: 8'h00, byte_valid: 1'b0, status: code,
                                        run_last: 1'b0});
         mode = MODE_STOP;
      endfunction

      function void close_clean();
         string trailer;
         trailer = "</style>\n";
         for (int i = 0; i < trailer.len(); i++) emit(trailer[i]);
         conclude(ST_DONE);
      endfunction

      function void open_value();
         emit(CH_COLON);
         mode = MODE_VAL;
         space_due = 1'b0;
         mid_word = 1'b0;
      endfunction

      // Works out every beat that one accepted byte causes and queues them in order.
      function void note_byte(logic [7:0] c, logic final_byte);
         string header;
         string tag_text;
         bit    blank;
         header = "<style>\n";
         tag_text = "/style>";
         blank = (c <= CH_SPACE);
         burst.delete();
         if (!started) begin
            started = 1'b1;
            for (int i = 0; i < header.len(); i++) emit(header[i]);
         end
         case (mode)
            MODE_TOP: begin
               if (!blank) begin
                  if (c == CH_LT) begin
                     if (close_tag_required) begin
                        tag_pos = 0;
                        mode = MODE_TAG;
                     end else begin
                        close_clean();
                     end
                  end else if (c == CH_LBRACE) begin
                     emit(CH_LBRACE);
                     semi_held = 1'b0;
                     mode = MODE_BLOCK;
                  end else begin
                     emit(c);
                     held_n = 0;
                     mode = MODE_SEL;
                  end
               end
            end
            MODE_SEL: begin
               if (c == CH_LBRACE) begin
                  held_n = 0;
                  emit(CH_LBRACE);
                  semi_held = 1'b0;
                  mode = MODE_BLOCK;
               end else if (blank) begin
                  if (held_n >= HELD_DEPTH) begin
                     conclude(ST_OVERFLOW);
                  end else begin
                     held_ws[held_n] = c;
                     held_n++;
                  end
               end else begin
                  // Whitespace inside the selector is replayed once more text follows.
                  for (int i = 0; i < held_n; i++) emit(held_ws[i]);
                  held_n = 0;
                  emit(c);
               end
            end
            MODE_BLOCK: begin
               if (!blank) begin
                  if (c == CH_RBRACE) begin
                     semi_held = 1'b0;
                     emit(CH_RBRACE);
                     emit(CH_NL);
                     mode = MODE_TOP;
                  end else begin
                     if (semi_held) begin
                        emit(CH_SEMI);
                        semi_held = 1'b0;
                     end
                     if (c == CH_COLON) begin
                        open_value();
                     end else begin
                        emit(c);
                        mode = MODE_KEY;
                     end
                  end
               end
            end
            MODE_KEY: begin
               if (c == CH_COLON) open_value();
               else emit(c);
            end
            MODE_VAL: begin
               if (blank) begin
                  mid_word = 1'b0;
               end else if (c == CH_SEMI) begin
                  semi_held = 1'b1;
                  mid_word = 1'b0;
                  mode = MODE_BLOCK;
               end else begin
                  if (!mid_word) begin
                     if (space_due) emit(CH_SPACE);
                     space_due = 1'b1;
                     mid_word = 1'b1;
                  end
                  emit(c);
               end
            end
            MODE_TAG: begin
               if (tag_pos < tag_text.len() && c == tag_text[tag_pos]) begin
                  tag_pos++;
                  if (tag_pos == tag_text.len()) close_clean();
               end else begin
                  conclude(ST_BAD_TAG);
               end
            end
            default: begin
            end
         endcase
         if (final_byte) begin
            case (mode)
               MODE_TOP:   close_clean();
               MODE_SEL:   conclude(ST_NO_BRACE);
               MODE_BLOCK: conclude(ST_UNCLOSED);
               MODE_KEY:   conclude(ST_NO_COLON);
               MODE_VAL:   conclude(ST_UNTERM);
               MODE_TAG:   conclude(ST_BAD_TAG);
               default: begin
               end
            endcase
            rearm();
         end
         if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
         foreach (burst[i]) minified_q.push_back(burst[i]);
      endfunction

      task check_beat(logic [15:0] data, logic user, logic lastf);
         css_beat_type want;
         logic [15:0]  want_data;
         beats_checked++;
         if (user === 1'b0 && !$isunknown(data[10:8])) status_hits[data[10:8]]++;
         if (minified_q.size() == 0) begin
            report($sformatf("unexpected beat data=%h user=%b last=%b", data, user, lastf));
         end else begin
            want = minified_q.pop_front();
            want_data = {5'b0, want.status, want.out_byte};
            if (data !== want_data || user !== want.byte_valid || lastf !== want.run_last)
               report($sformatf("beat %0d: got data=%h user=%b last=%b, expected %h/%b/%b",
                                beats_checked, data, user, lastf,
                                want_data, want.byte_valid, want.run_last));
         end
      endtask

      task report(string what);
         mismatches++;
         if (mismatches <= 20) $display("mismatch: %s", what);
      endtask
   endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench of css_stream_minifier_top: stimulus, handshakes, watchdog and verdict.
// Depends on css_min_pkg and on the scoreboard in css_min_tb_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import css_min_pkg::*;
   import css_min_tb_pkg::*;

   // Cycles with no beat on either side before the run is declared hung. The slowest
   // legitimate gap is a settle pause plus a long burst, far below this.
   localparam int STALL_LIMIT   = 2000;
   // Cycles allowed after the last expected beat before a register write or the verdict.
   localparam int SETTLE_CYCLES = 32;
   // Input bytes to send in all, the directed part included.
   localparam int RANDOM_BYTES  = 370;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   css_minify_scoreboard board;
   logic [7:0]           text_q[$];
   int unsigned          bytes_sent;
   int unsigned          messages_sent;
   int unsigned          idle_cycles = 0;
   // While set, neither side idles, so the block runs at full rate for a stretch.
   bit                   steady;

   css_stream_minifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls in roughly a quarter of the cycles, chosen afresh at each
   // falling edge so that stalls land on every phase of a burst.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
   end

   // Beats are taken at the rising edge, where the handshake signals still
   // hold the values of the cycle just ending. The input beat is noted before the
   // result beat is checked, although a result can never belong to the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("watchdog: no beat for %0d cycles, %0d beats still due",
                        idle_cycles, board.minified_q.size());
               $display("[css_stream_minifier_top] ERROR");
               $finish;
            end
         end
      end
   end

   function automatic void push_blank(int unsigned n);
      repeat (n) text_q.push_back(8'($urandom_range(0, 32)));
   endfunction

   // Word characters avoid whitespace and every character that steers the parser;
   // most are lower-case letters, the rest anything up to 0xff.
   function automatic void push_word(int unsigned n);
      logic [7:0] c;
      repeat (n) begin
         if ($urandom_range(0, 3) != 0) c = 8'h61 + 8'($urandom_range(0, 25));
         else c = 8'($urandom_range(33, 255));
         while (c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_SEMI ||
                c == CH_LT)
            c = 8'($urandom_range(33, 255));
         text_q.push_back(c);
      end
   endfunction

   // Drives one input beat. The sender idles first at random, then holds the byte
   // until the handshake edge, and hands over at the next falling edge.
   task automatic send_byte(input logic [7:0] value, input logic final_byte);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= final_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      messages_sent++;
   endtask

   // Stops the sender until every expected beat has arrived, then lets the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.minified_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_close_tag(input logic value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      board.close_tag_required = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Builds one random message. Most are style sheets with random content, of which
   // some are cut short and some end with a closing tag (sometimes broken); others pile
   // whitespace after a selector up to and just past the held limit, and the rest are
   // plain noise.
   task automatic compose_message();
      string       closing;
      int unsigned kind;
      int unsigned rules;
      int unsigned words;
      int unsigned props;
      int unsigned vals;
      int unsigned base;
      int unsigned keep;
      closing = "/style>";
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 22) begin
         push_word($urandom_range(1, 2));
         push_blank($urandom_range(HELD_DEPTH - 2, HELD_DEPTH + 1));
         if ($urandom_range(0, 1)) push_word(1);
         text_q.push_back(CH_LBRACE);
         text_q.push_back(CH_RBRACE);
      end else begin
         push_blank($urandom_range(0, 2));
         rules = $urandom_range(1, 2);
         repeat (rules) begin
            words = $urandom_range(0, 2);
            for (int w = 0; w < words; w++) begin
               if (w > 0) push_blank($urandom_range(1, 2));
               push_word($urandom_range(1, 4));
            end
            push_blank($urandom_range(0, 3));
            text_q.push_back(CH_LBRACE);
            props = $urandom_range(0, 3);
            for (int p = 0; p < props; p++) begin
               push_blank($urandom_range(0, 1));
               push_word($urandom_range(0, 3));
               text_q.push_back(CH_COLON);
               push_blank($urandom_range(0, 1));
               vals = $urandom_range(1, 3);
               for (int v = 0; v < vals; v++) begin
                  if (v > 0) push_blank($urandom_range(1, 2));
                  push_word($urandom_range(1, 3));
               end
               push_blank($urandom_range(0, 1));
               // The semicolon after the last property is optional.
               if (p < props - 1 || $urandom_range(0, 1)) text_q.push_back(CH_SEMI);
            end
            push_blank($urandom_range(0, 1));
            text_q.push_back(CH_RBRACE);
            push_blank($urandom_range(0, 2));
         end
         if (kind >= 70) begin
            base = text_q.size();
            text_q.push_back(CH_LT);
            for (int i = 0; i < closing.len(); i++) text_q.push_back(closing[i]);
            if (kind >= 85)
               text_q[base + $urandom_range(1, closing.len())] = 8'($urandom_range(0, 255));
         end else if (kind >= 55) begin
            keep = $urandom_range(1, text_q.size());
            while (text_q.size() > keep) void'(text_q.pop_back());
         end
      end
      if (text_q.size() == 0) push_word(1);
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = 1'b0;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      steady        = 1'b0;
      bytes_sent    = 0;
      messages_sent = 0;
      board = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_close_tag(1'b0);

      // Directed part with the tag optional. A clean rule with a NUL and a 0xff byte,
      // whitespace inside and after the selector, an empty key and a dropped final
      // semicolon; then each way a message can end early; then a bare '<' that ends
      // the sheet, followed by bytes that must produce nothing.
      text_q = '{8'h00, 8'h61, CH_SPACE, 8'h62, 8'h09, CH_LBRACE, CH_COLON, 8'hff,
                 CH_SEMI, CH_RBRACE};
      send_message();
      text_q = '{CH_LBRACE, 8'h6b};
      send_message();
      text_q = '{8'h70};
      send_message();
      text_q = '{CH_LBRACE, CH_COLON, 8'h76};
      send_message();
      text_q = '{CH_LBRACE};
      send_message();
      text_q = '{CH_LT, 8'h78, 8'h79};
      send_message();

      // With the tag required: a tag broken part way, and one cut off at its first byte.
      drain_results();
      write_close_tag(1'b1);
      text_q = '{CH_LT, 8'h2f, 8'h78};
      send_message();
      text_q = '{CH_LT};
      send_message();

      // Random part. Now and then the sender waits for every beat and the register
      // is rewritten; a stretch in the middle runs with no idling on either side.
      drain_results();
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 4) == 0) begin
            drain_results();
            write_close_tag(1'($urandom_range(0, 1)));
         end
         steady = (bytes_sent >= 160 && bytes_sent < 250);
         compose_message();
         send_message();
      end
      steady = 1'b0;

      drain_results();
      $display("Run covered %0d CSS bytes in %0d messages, %0d result beats checked.",
               bytes_sent, messages_sent, board.beats_checked);
      $display("Statuses seen: done %0d, no brace %0d, no colon %0d, unterminated %0d, %s",
               board.status_hits[ST_DONE], board.status_hits[ST_NO_BRACE],
               board.status_hits[ST_NO_COLON], board.status_hits[ST_UNTERM],
               $sformatf("unclosed %0d, bad tag %0d, overflow %0d.",
                         board.status_hits[ST_UNCLOSED], board.status_hits[ST_BAD_TAG],
                         board.status_hits[ST_OVERFLOW]));
      if (board.mismatches == 0) begin
         $display("[css_stream_minifier_top] OK");
      end else begin
         $display("[css_stream_minifier_top] ERROR");
      end
      $finish;
   end

endmodule
